/* hdl/tcsa_pkg.sv */
package tcsa_pkg;

	typedef enum logic [2:0] {
		CMD_CLEAR   = 3'd0,
		CMD_WEIGHT  = 3'd1,
		CMD_BIAS    = 3'd2,
		CMD_SCATTER = 3'd3,
		CMD_READ    = 3'd4
	} cmd_e;

	typedef enum logic [2:0] {
		REG_IN_PER_GROUP  = 3'd0,
		REG_OUT_PER_GROUP = 3'd1,
		REG_VSTRIDE       = 3'd2,
		REG_HSTRIDE       = 3'd3,
		REG_PAD_TOP       = 3'd4,
		REG_LEFT_PAD      = 3'd5,
		REG_OUT_HEIGHT    = 3'd6,
		REG_OUT_WIDTH     = 3'd7
	} reg_e;

	localparam int CFG_DATA_W = 6;
	// output coordinates and channel bases stay well below 2^11
	localparam int CRD_W = 12;
	localparam int BASE_W = 12;

	typedef struct packed {
		logic [4:0] in_per_group;
		logic [4:0] out_per_group;
		logic [3:0] vstride;
		logic [3:0] hstride;
		logic [1:0] pad_top;
		logic [1:0] left_pad;
		logic [5:0] out_height;
		logic [5:0] out_width;
	} cfg_t;

	typedef struct packed {
		cmd_e              op;
		logic [3:0]        ic;
		logic [3:0]        oc;
		logic [1:0]        kr;
		logic [1:0]        kc;
		logic [4:0]        row;
		logic [4:0]        col;
		logic signed [15:0] value;
		logic [BASE_W-1:0] oc_base;
	} item_t;

	function automatic logic signed [39:0] sat_acc(input logic signed [40:0] v);
		logic signed [39:0] r;
		if (v[40] != v[39])
			r = v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
		else
			r = v[39:0];
		return r;
	endfunction

endpackage

/* hdl/tcsa_ram.sv */
module tcsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/tcsa_front.sv */
module tcsa_front import tcsa_pkg::*; #(
	parameter int MAX_IN_CHANNELS = 16,
	parameter int MAX_OUT_CHANNELS = 16,
	parameter int KERNEL_H = 4,
	parameter int KERNEL_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         command,
	input  logic [3:0]         in_channel,
	input  logic [3:0]         out_channel,
	input  logic [1:0]         kernel_row,
	input  logic [1:0]         kernel_col,
	input  logic [4:0]         pixel_row,
	input  logic [4:0]         pixel_col,
	input  logic [4:0]         read_row,
	input  logic [4:0]         read_col,
	input  logic signed [15:0] value,
	input  cfg_t               cfg,
	input  logic               init,
	input  logic               full,
	output logic               busy,
	output logic               push,
	output item_t              item
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t    state_q;
	item_t      item_q;
	logic [5:0] rem_q;
	logic [3:0] quo_q;
	logic [1:0] step_q;
	logic       accept;
	logic [5:0] divisor;
	logic [5:0] rem_sh;
	logic       ge;

	assign busy = init || (state_q != F_IDLE);
	assign accept = start && !busy;
	assign push = (state_q == F_PUSH) && !full;

	// restoring division of the input channel by inputs per group, one bit a cycle
	assign divisor = (cfg.in_per_group == 5'd0) ? 6'd1 : {1'b0, cfg.in_per_group};
	assign rem_sh = {rem_q[4:0], item_q.ic[step_q]};
	assign ge = rem_sh >= divisor;

	always_comb begin
		item = item_q;
		item.oc_base = BASE_W'(quo_q * cfg.out_per_group);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						case (command)
							CMD_SCATTER: begin
								if (int'(in_channel) < MAX_IN_CHANNELS &&
								    cfg.out_per_group != 5'd0) begin
									state_q <= F_DIV;
									step_q <= 2'd3;
								end
							end
							CMD_WEIGHT: begin
								if (int'(in_channel) < MAX_IN_CHANNELS &&
								    int'(out_channel) < MAX_OUT_CHANNELS &&
								    int'(kernel_row) < KERNEL_H &&
								    int'(kernel_col) < KERNEL_W)
									state_q <= F_PUSH;
							end
							CMD_BIAS: begin
								if (int'(out_channel) < MAX_OUT_CHANNELS)
									state_q <= F_PUSH;
							end
							CMD_CLEAR, CMD_READ: state_q <= F_PUSH;
							default: state_q <= F_IDLE;
						endcase
					end
				end
				F_DIV: begin
					if (step_q == 2'd0)
						state_q <= F_PUSH;
					else
						step_q <= step_q - 2'd1;
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op <= cmd_e'(command);
			item_q.ic <= in_channel;
			item_q.oc <= out_channel;
			item_q.kr <= kernel_row;
			item_q.kc <= kernel_col;
			item_q.row <= (command == CMD_READ) ? read_row : pixel_row;
			item_q.col <= (command == CMD_READ) ? read_col : pixel_col;
			item_q.value <= value;
			item_q.oc_base <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == F_DIV) begin
			rem_q <= ge ? (rem_sh - divisor) : rem_sh;
			quo_q[step_q] <= ge;
		end
	end

endmodule

/* hdl/tcsa_fifo.sv */
module tcsa_fifo import tcsa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	input  logic  pop,
	output item_t dout,
	output logic  full,
	output logic  empty
);

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

endmodule

/* hdl/tcsa_back.sv */
module tcsa_back import tcsa_pkg::*; #(
	parameter int MAX_IN_CHANNELS = 16,
	parameter int MAX_OUT_CHANNELS = 16,
	parameter int MAX_OUT_HEIGHT = 32,
	parameter int MAX_OUT_WIDTH = 32,
	parameter int KERNEL_H = 4,
	parameter int KERNEL_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               empty,
	input  item_t              head,
	output logic               pop,
	output logic               init,
	output logic               result_valid,
	output logic signed [39:0] result_value
);

	localparam int ACC_DEPTH = MAX_OUT_CHANNELS * MAX_OUT_HEIGHT * MAX_OUT_WIDTH;
	localparam int AAW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int W_DEPTH = MAX_IN_CHANNELS * MAX_OUT_CHANNELS * KERNEL_H * KERNEL_W;
	localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
	localparam int KRW = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
	localparam int KCW = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;
	localparam int BIW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

	typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_SCAT, B_DRAIN, B_RD1, B_RD2} bstate_t;

	function automatic logic [WAW-1:0] w_addr(input int ic, input int j, input int kr,
		input int kc);
		return WAW'(((ic * MAX_OUT_CHANNELS + j) * KERNEL_H + kr) * KERNEL_W + kc);
	endfunction

	function automatic logic [AAW-1:0] a_addr(input int oc, input int r, input int c);
		return AAW'((oc * MAX_OUT_HEIGHT + r) * MAX_OUT_WIDTH + c);
	endfunction

	bstate_t            state_q;
	logic               init_q;
	logic [AAW-1:0]     clr_q;
	item_t              cur_q;
	logic [4:0]         j_q;
	logic [KRW-1:0]     kr_q;
	logic [KCW-1:0]     kc_q;
	logic               in_range_q;
	logic signed [15:0] bias_q [MAX_OUT_CHANNELS];

	logic               v_s1, v_s2;
	logic [AAW-1:0]     aaddr_s1, aaddr_s2;
	logic signed [31:0] prod_s2;
	logic signed [39:0] acc_s2;

	logic [CRD_W-1:0]   rows_n, cols_n, r_s0, c_s0;
	logic [3:0]         sh_e, sw_e;
	logic [BASE_W:0]    oc_s0;
	logic               tap_ok, last_tap, read_ok;
	logic [AAW-1:0]     tap_addr, read_addr;
	logic               acc_we;
	logic [AAW-1:0]     acc_waddr, acc_raddr;
	logic [39:0]        acc_wdata, acc_rdata;
	logic               w_we;
	logic [WAW-1:0]     w_waddr, w_raddr;
	logic [15:0]        w_rdata;
	logic signed [39:0] sum_s2;
	logic signed [39:0] read_sum;

	assign init = init_q;
	assign pop = (state_q == B_IDLE) && !empty;

	assign rows_n = (CRD_W'(cfg.out_height) > CRD_W'(MAX_OUT_HEIGHT)) ?
		CRD_W'(MAX_OUT_HEIGHT) : CRD_W'(cfg.out_height);
	assign cols_n = (CRD_W'(cfg.out_width) > CRD_W'(MAX_OUT_WIDTH)) ?
		CRD_W'(MAX_OUT_WIDTH) : CRD_W'(cfg.out_width);
	assign sh_e = (cfg.vstride == 4'd0) ? 4'd1 : cfg.vstride;
	assign sw_e = (cfg.hstride == 4'd0) ? 4'd1 : cfg.hstride;

	// tap generation; negative coordinates wrap and fail the bound check
	assign r_s0 = CRD_W'(cur_q.row) * CRD_W'(sh_e) - CRD_W'(cfg.pad_top) + CRD_W'(kr_q);
	assign c_s0 = CRD_W'(cur_q.col) * CRD_W'(sw_e) - CRD_W'(cfg.left_pad) + CRD_W'(kc_q);
	assign oc_s0 = (BASE_W + 1)'(cur_q.oc_base) + (BASE_W + 1)'(j_q);
	assign tap_ok = (int'(j_q) < MAX_OUT_CHANNELS) && (int'(oc_s0) < MAX_OUT_CHANNELS) &&
		(r_s0 < rows_n) && (c_s0 < cols_n);
	assign last_tap = (kc_q == KCW'(KERNEL_W - 1)) && (kr_q == KRW'(KERNEL_H - 1)) &&
		(j_q == cfg.out_per_group - 5'd1);
	assign tap_addr = a_addr(int'(oc_s0), int'(r_s0), int'(c_s0));

	assign read_ok = (int'(cur_q.oc) < MAX_OUT_CHANNELS) &&
		(CRD_W'(cur_q.row) < rows_n) && (CRD_W'(cur_q.col) < cols_n);
	assign read_addr = a_addr(int'(cur_q.oc), int'(cur_q.row), int'(cur_q.col));

	assign sum_s2 = sat_acc({acc_s2[39], acc_s2} + {{9{prod_s2[31]}}, prod_s2});
	assign read_sum = sat_acc({acc_rdata[39], acc_rdata} +
		{{17{bias_q[BIW'(cur_q.oc)][15]}}, bias_q[BIW'(cur_q.oc)], 8'd0});

	assign acc_we = (state_q == B_CLEAR) || v_s2;
	assign acc_waddr = (state_q == B_CLEAR) ? clr_q : aaddr_s2;
	assign acc_wdata = (state_q == B_CLEAR) ? 40'd0 : sum_s2;
	assign acc_raddr = (state_q == B_RD1) ? read_addr : tap_addr;

	assign w_we = pop && (head.op == CMD_WEIGHT);
	assign w_waddr = w_addr(int'(head.ic), int'(head.oc), int'(head.kr), int'(head.kc));
	assign w_raddr = w_addr(int'(cur_q.ic), int'(j_q), int'(kr_q), int'(kc_q));

	tcsa_ram #(.WIDTH(40), .DEPTH(ACC_DEPTH)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	tcsa_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_w_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (head.value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			init_q <= 1'b1;
			clr_q <= '0;
			j_q <= '0;
			kr_q <= '0;
			kc_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == B_RD2);
			case (state_q)
				B_CLEAR: begin
					if (clr_q == AAW'(ACC_DEPTH - 1)) begin
						clr_q <= '0;
						init_q <= 1'b0;
						state_q <= B_IDLE;
					end else begin
						clr_q <= clr_q + AAW'(1);
					end
				end
				B_IDLE: begin
					if (!empty) begin
						j_q <= '0;
						kr_q <= '0;
						kc_q <= '0;
						case (head.op)
							CMD_CLEAR: state_q <= B_CLEAR;
							CMD_SCATTER: state_q <= B_SCAT;
							CMD_READ: state_q <= B_RD1;
							default: state_q <= B_IDLE;
						endcase
					end
				end
				B_SCAT: begin
					if (last_tap)
						state_q <= B_DRAIN;
					if (kc_q == KCW'(KERNEL_W - 1)) begin
						kc_q <= '0;
						if (kr_q == KRW'(KERNEL_H - 1)) begin
							kr_q <= '0;
							j_q <= j_q + 5'd1;
						end else begin
							kr_q <= kr_q + KRW'(1);
						end
					end else begin
						kc_q <= kc_q + KCW'(1);
					end
				end
				B_DRAIN: begin
					// last write lands before the next item reads
					if (!v_s1 && !v_s2)
						state_q <= B_IDLE;
				end
				B_RD1: state_q <= B_RD2;
				B_RD2: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < MAX_OUT_CHANNELS; i++)
				bias_q[i] <= '0;
		end else begin
			v_s1 <= (state_q == B_SCAT) && tap_ok;
			v_s2 <= v_s1;
			if (pop && head.op == CMD_BIAS)
				bias_q[BIW'(head.oc)] <= head.value;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		aaddr_s1 <= tap_addr;
		aaddr_s2 <= aaddr_s1;
		prod_s2 <= cur_q.value * $signed(w_rdata);
		acc_s2 <= acc_rdata;
		if (state_q == B_RD1)
			in_range_q <= read_ok;
		if (state_q == B_RD2)
			result_value <= in_range_q ? read_sum : 40'sd0;
	end

endmodule

/* hdl/transposed_conv2d_scatter_accumulate.sv */
// Grouped 2-D transposed convolution by scatter. An item is taken when start is high
// and busy is low; a read item returns one result_value on a single-cycle result_valid
// strobe that the receiver cannot hold off, and no other item returns anything. After
// reset, and for each clear item, the accumulator memory is swept to zero at one entry
// a cycle, all MAX_OUT_CHANNELS * MAX_OUT_HEIGHT * MAX_OUT_WIDTH entries (16384 by
// default); busy stays high through the sweep after reset. A scatter item holds the
// front for the group division and while it is queued; in the back it is popped, then
// takes out_per_group * KERNEL_H * KERNEL_W taps, one multiply-accumulate each through
// the accumulator memory port, and then a pipeline drain. A read passes through the
// back-end pop, B_RD1 and B_RD2 states and its strobe comes in the cycle after B_RD2;
// weight and bias loads land at the pop. A two-entry queue lets the front take items
// while the back works; busy also stays high while the front waits on a full queue.
module transposed_conv2d_scatter_accumulate import tcsa_pkg::*; #(
	parameter int MAX_IN_CHANNELS = 16,
	parameter int MAX_OUT_CHANNELS = 16,
	parameter int MAX_OUT_HEIGHT = 32,
	parameter int MAX_OUT_WIDTH = 32,
	parameter int KERNEL_H = 4,
	parameter int KERNEL_W = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            command,
	input  logic [3:0]            in_channel,
	input  logic [3:0]            out_channel,
	input  logic [1:0]            kernel_row,
	input  logic [1:0]            kernel_col,
	input  logic [4:0]            pixel_row,
	input  logic [4:0]            pixel_col,
	input  logic [4:0]            read_row,
	input  logic [4:0]            read_col,
	input  logic signed [15:0]    value,
	output logic                  result_valid,
	output logic signed [39:0]    result_value,
	input  logic                  cfg_write,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  init, full, empty, push, pop;
	item_t q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_per_group <= 5'd1;
			cfg_q.out_per_group <= 5'd1;
			cfg_q.vstride <= 4'd1;
			cfg_q.hstride <= 4'd1;
			cfg_q.pad_top <= 2'd0;
			cfg_q.left_pad <= 2'd0;
			cfg_q.out_height <= 6'd32;
			cfg_q.out_width <= 6'd32;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IN_PER_GROUP: cfg_q.in_per_group <= cfg_data[4:0];
				REG_OUT_PER_GROUP: cfg_q.out_per_group <= cfg_data[4:0];
				REG_VSTRIDE: cfg_q.vstride <= cfg_data[3:0];
				REG_HSTRIDE: cfg_q.hstride <= cfg_data[3:0];
				REG_PAD_TOP: cfg_q.pad_top <= cfg_data[1:0];
				REG_LEFT_PAD: cfg_q.left_pad <= cfg_data[1:0];
				REG_OUT_HEIGHT: cfg_q.out_height <= cfg_data[5:0];
				REG_OUT_WIDTH: cfg_q.out_width <= cfg_data[5:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	tcsa_front #(
		.MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
		.MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
		.KERNEL_H         (KERNEL_H),
		.KERNEL_W         (KERNEL_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.in_channel  (in_channel),
		.out_channel (out_channel),
		.kernel_row  (kernel_row),
		.kernel_col  (kernel_col),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.read_row    (read_row),
		.read_col    (read_col),
		.value       (value),
		.cfg         (cfg_q),
		.init        (init),
		.full        (full),
		.busy        (busy),
		.push        (push),
		.item        (q_in)
	);

	tcsa_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_in),
		.pop    (pop),
		.dout   (q_out),
		.full   (full),
		.empty  (empty)
	);

	tcsa_back #(
		.MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
		.MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
		.MAX_OUT_HEIGHT   (MAX_OUT_HEIGHT),
		.MAX_OUT_WIDTH    (MAX_OUT_WIDTH),
		.KERNEL_H         (KERNEL_H),
		.KERNEL_W         (KERNEL_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (empty),
		.head         (q_out),
		.pop          (pop),
		.init         (init),
		.result_valid (result_valid),
		.result_value (result_value)
	);

endmodule

/* hdl/tcsa_checker.sv */
module tcsa_checker import tcsa_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] command,
	input logic       result_valid
);

	// a read needs at least a pop and the B_RD1 and B_RD2 states in the back
	a_strobe_gap1: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobes closer than three cycles");

	a_strobe_gap2: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ##2 !result_valid)
		else $error("result strobe two cycles after another");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_CLEAR || command == CMD_READ ||
		command == CMD_BIAS))
		|=> busy)
		else $error("front free right after taking a queued item");

	a_no_result_in_reset_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(!arst_n)) |-> !result_valid)
		else $error("result during reset sweep");

endmodule

bind transposed_conv2d_scatter_accumulate tcsa_checker u_tcsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.command      (command),
	.result_valid (result_valid)
);

/* dv/tcsa_checker.sv */
`timescale 1ns / 100ps

module tcsa_scoreboard import tcsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [2:0]            command,
	input  logic [3:0]            in_channel,
	input  logic [3:0]            out_channel,
	input  logic [1:0]            kernel_row,
	input  logic [1:0]            kernel_col,
	input  logic [4:0]            pixel_row,
	input  logic [4:0]            pixel_col,
	input  logic [4:0]            read_row,
	input  logic [4:0]            read_col,
	input  logic signed [15:0]    value,
	input  logic                  result_valid,
	input  logic signed [39:0]    result_value,
	input  logic                  cfg_write,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fails,
	output int                    pending
);

	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -ACC_HI - 1;

	cfg_t                cfg;
	longint              acc_mem [16384];
	logic signed [15:0]  wgt_mem [4096];
	logic signed [15:0]  bias_mem [16];
	logic signed [39:0]  expected_reads [$];

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		fails++;
	endtask

	function automatic longint clamp40(input longint v);
		if (v > ACC_HI) return ACC_HI;
		if (v < ACC_LO) return ACC_LO;
		return v;
	endfunction

	function automatic int rows_used();
		return (cfg.out_height > 32) ? 32 : int'(cfg.out_height);
	endfunction

	function automatic int cols_used();
		return (cfg.out_width > 32) ? 32 : int'(cfg.out_width);
	endfunction

	function automatic void scatter_pixel(input int ic, input int pr, input int pc,
			input longint pix);
		int ipg, sh, sw, g, oc, r, c, a;
		ipg = cfg.in_per_group ? int'(cfg.in_per_group) : 1;
		sh = cfg.vstride ? int'(cfg.vstride) : 1;
		sw = cfg.hstride ? int'(cfg.hstride) : 1;
		g = ic / ipg;
		for (int j = 0; j < int'(cfg.out_per_group); j++) begin
			oc = g * int'(cfg.out_per_group) + j;
			if (j >= 16 || oc >= 16) continue;
			for (int kr = 0; kr < 4; kr++) begin
				r = pr * sh - int'(cfg.pad_top) + kr;
				if (r < 0 || r >= rows_used()) continue;
				for (int kc = 0; kc < 4; kc++) begin
					c = pc * sw - int'(cfg.left_pad) + kc;
					if (c < 0 || c >= cols_used()) continue;
					a = (oc * 32 + r) * 32 + c;
					acc_mem[a] = clamp40(acc_mem[a]
						+ pix * longint'(wgt_mem[((ic * 16 + j) * 4 + kr) * 4 + kc]));
				end
			end
		end
	endfunction

	function automatic logic signed [39:0] read_element(input int oc, input int rr,
			input int rc);
		longint r;
		r = 0;
		if (oc < 16 && rr < rows_used() && rc < cols_used())
			r = clamp40(acc_mem[(oc * 32 + rr) * 32 + rc] + longint'(bias_mem[oc]) * 256);
		return r[39:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '{in_per_group: 5'd1, out_per_group: 5'd1, vstride: 4'd1,
				hstride: 4'd1, pad_top: 2'd0, left_pad: 2'd0,
				out_height: 6'd32, out_width: 6'd32};
			foreach (acc_mem[i]) acc_mem[i] = 0;
			foreach (bias_mem[i]) bias_mem[i] = '0;
			expected_reads.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (result_valid) begin
				if (expected_reads.size() == 0)
					report_mismatch($sformatf("unexpected result %0d", result_value));
				else begin
					if (result_value !== expected_reads[0])
						report_mismatch($sformatf("result_value %0d, expected %0d",
							result_value, expected_reads[0]));
					void'(expected_reads.pop_front());
				end
			end
			if (start && !busy) begin
				case (cmd_e'(command))
					CMD_CLEAR:   foreach (acc_mem[i]) acc_mem[i] = 0;
					CMD_WEIGHT:  wgt_mem[((in_channel * 16 + out_channel) * 4 + kernel_row) * 4
						+ kernel_col] = value;
					CMD_BIAS:    bias_mem[out_channel] = value;
					CMD_SCATTER: scatter_pixel(in_channel, pixel_row, pixel_col, value);
					CMD_READ:    expected_reads.push_back(read_element(out_channel,
						read_row, read_col));
					default: ;
				endcase
			end
			pending = expected_reads.size();
			if (cfg_write) begin
				case (reg_e'(cfg_index))
					REG_IN_PER_GROUP:  cfg.in_per_group <= cfg_data[4:0];
					REG_OUT_PER_GROUP: cfg.out_per_group <= cfg_data[4:0];
					REG_VSTRIDE:       cfg.vstride <= cfg_data[3:0];
					REG_HSTRIDE:       cfg.hstride <= cfg_data[3:0];
					REG_PAD_TOP:       cfg.pad_top <= cfg_data[1:0];
					REG_LEFT_PAD:      cfg.left_pad <= cfg_data[1:0];
					REG_OUT_HEIGHT:    cfg.out_height <= cfg_data[5:0];
					REG_OUT_WIDTH:     cfg.out_width <= cfg_data[5:0];
					default: ;
				endcase
			end
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top import tcsa_pkg::*;;

	localparam int STALL_LIMIT = 100000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [2:0]            command = '0;
	logic [3:0]            in_channel = '0;
	logic [3:0]            out_channel = '0;
	logic [1:0]            kernel_row = '0;
	logic [1:0]            kernel_col = '0;
	logic [4:0]            pixel_row = '0;
	logic [4:0]            pixel_col = '0;
	logic [4:0]            read_row = '0;
	logic [4:0]            read_col = '0;
	logic signed [15:0]    value = '0;
	logic                  result_valid;
	logic signed [39:0]    result_value;
	logic                  cfg_write = 1'b0;
	logic [2:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, pending_reads, stall_cycles;
	int cur_ipg = 1, cur_opg = 1, idle_pct = 0;
	bit wt_done [4096];

	always #1 clk = ~clk;

	transposed_conv2d_scatter_accumulate dut (.*);

	tcsa_scoreboard chk (.*, .fails(fail_count), .pending(pending_reads));

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL transposed_conv2d_scatter_accumulate");
				$finish;
			end
		end
	end

	task automatic send_item(input int cmd, input int ic, input int oc, input int kr,
			input int kc, input int pr, input int pc, input int rr, input int rc,
			input int val);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end else
			@(negedge clk);
		command = 3'(cmd); in_channel = 4'(ic); out_channel = 4'(oc);
		kernel_row = 2'(kr); kernel_col = 2'(kc); pixel_row = 5'(pr); pixel_col = 5'(pc);
		read_row = 5'(rr); read_col = 5'(rc); value = 16'(val);
		start = 1'b1;
		if (cmd == CMD_WEIGHT)
			wt_done[(((ic & 15) * 16 + (oc & 15)) * 4 + (kr & 3)) * 4 + (kc & 3)] = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
	endtask

	task automatic write_reg(input reg_e idx, input int data);
		@(negedge clk);
		cfg_write = 1'b1; cfg_index = idx; cfg_data = CFG_DATA_W'(data);
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == REG_IN_PER_GROUP) cur_ipg = data & 31;
		if (idx == REG_OUT_PER_GROUP) cur_opg = data & 31;
	endtask

	task automatic set_config(input int ipg, input int opg, input int sh, input int sw,
			input int pt, input int pl, input int oh, input int ow);
		write_reg(REG_IN_PER_GROUP, ipg);
		write_reg(REG_OUT_PER_GROUP, opg);
		write_reg(REG_VSTRIDE, sh);
		write_reg(REG_HSTRIDE, sw);
		write_reg(REG_PAD_TOP, pt);
		write_reg(REG_LEFT_PAD, pl);
		write_reg(REG_OUT_HEIGHT, oh);
		write_reg(REG_OUT_WIDTH, ow);
	endtask

	// a final read returns only after all earlier work is done, so the block is idle
	task automatic drain_block();
		send_item(CMD_READ, 0, $urandom, 0, 0, 0, 0, $urandom, $urandom, 0);
		@(negedge clk);
		start = 1'b0;
		while (pending_reads != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// first weight a scatter of this channel would use that was never loaded, or -1
	function automatic int missing_weight(input int ic);
		int ipg, g, oc;
		ipg = cur_ipg ? cur_ipg : 1;
		g = ic / ipg;
		for (int j = 0; j < cur_opg; j++) begin
			oc = g * cur_opg + j;
			if (j >= 16 || oc >= 16) continue;
			for (int t = 0; t < 16; t++)
				if (!wt_done[(ic * 16 + j) * 16 + t]) return (ic * 16 + j) * 16 + t;
		end
		return -1;
	endfunction

	task automatic random_item();
		int pick, cmd, ic, miss;
		pick = $urandom_range(999);
		ic = $urandom_range(15);
		if (pick < 8) cmd = CMD_CLEAR;
		else if (pick < 160) cmd = CMD_WEIGHT;
		else if (pick < 240) cmd = CMD_BIAS;
		else if (pick < 650) cmd = CMD_SCATTER;
		else if (pick < 950) cmd = CMD_READ;
		else cmd = $urandom_range(5, 7);
		miss = (cmd == CMD_SCATTER) ? missing_weight(ic) : -1;
		if (miss >= 0)
			send_item(CMD_WEIGHT, miss >> 8, (miss >> 4) & 15, (miss >> 2) & 3, miss & 3,
				$urandom, $urandom, $urandom, $urandom, $urandom);
		else
			send_item(cmd, ic, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
	endtask

	// drives one accumulator region into saturation with extreme operands
	task automatic saturate_phase(input int wv, input int bv);
		set_config(16, 1, 1, 1, 0, 0, 4, 4);
		send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_BIAS, 0, 0, 0, 0, 0, 0, 0, 0, bv);
		for (int t = 0; t < 16; t++)
			send_item(CMD_WEIGHT, 0, 0, t >> 2, t & 3, 0, 0, 0, 0, wv);
		for (int n = 0; n < 560; n++) begin
			if (n % 40 == 39)
				send_item(CMD_READ, $urandom, 0, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 4), $urandom_range(0, 4), $urandom);
			else
				send_item(CMD_SCATTER, 0, $urandom, $urandom, $urandom, $urandom_range(0, 1),
					$urandom_range(0, 1), $urandom, $urandom, -32768 + $urandom_range(0, 2));
		end
		drain_block();
	endtask

	int ph_cfg [7][8] = '{
		'{4, 4, 2, 2, 1, 1, 16, 16},
		'{16, 16, 1, 1, 0, 0, 32, 32},
		'{1, 1, 8, 8, 3, 3, 32, 32},
		'{0, 0, 0, 0, 0, 0, 63, 40},
		'{2, 8, 3, 1, 2, 0, 7, 13},
		'{8, 2, 1, 5, 3, 2, 1, 1},
		'{1, 16, 4, 4, 0, 3, 20, 9}
	};
	int ph_items [7] = '{120, 60, 120, 90, 120, 100, 60};
	int idle_modes [3] = '{0, 82, 26};

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);
		set_config(1, 1, 1, 1, 0, 0, 32, 32);

		// directed: extremes, every command, edge taps, unknown command
		send_item(CMD_BIAS, 0, 0, 0, 0, 0, 0, 0, 0, 32767);
		send_item(CMD_BIAS, 0, 15, 0, 0, 0, 0, 0, 0, -32768);
		for (int t = 0; t < 16; t++)
			send_item(CMD_WEIGHT, 0, 0, t >> 2, t & 3, 0, 0, 0, 0,
				(t == 0) ? 32767 : (t == 15) ? -32768 : $urandom);
		send_item(CMD_SCATTER, 0, 0, 0, 0, 0, 0, 0, 0, 32767);
		send_item(CMD_SCATTER, 0, 0, 0, 0, 31, 31, 0, 0, -32768);
		send_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_READ, 0, 0, 0, 0, 0, 0, 31, 31, 0);
		send_item(CMD_READ, 0, 15, 0, 0, 0, 0, 3, 3, 0);
		send_item(7, 15, 15, 3, 3, 31, 31, 31, 31, -1);
		send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		drain_block();

		for (int p = 0; p < 7; p++) begin
			idle_pct = 0;
			set_config(ph_cfg[p][0], ph_cfg[p][1], ph_cfg[p][2], ph_cfg[p][3],
				ph_cfg[p][4], ph_cfg[p][5], ph_cfg[p][6], ph_cfg[p][7]);
			idle_pct = idle_modes[p % 3];
			for (int n = 0; n < ph_items[p]; n++)
				random_item();
			drain_block();
		end

		idle_pct = idle_modes[1];
		saturate_phase(-32768, 32767);
		idle_pct = idle_modes[2];
		saturate_phase(32767, -32768);

		@(negedge clk);
		start = 1'b0;
		while (pending_reads != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("PASS transposed_conv2d_scatter_accumulate");
		else
			$display("FAIL transposed_conv2d_scatter_accumulate");
		$finish;
	end

endmodule
